>>> src/fiso_pkg.sv
package fiso_pkg;

   localparam int IDX_W      = 31;
   localparam int EXT_W      = 16;
   localparam int DIM_W      = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;
   localparam int PROD_W     = 2 * IDX_W;
   localparam int SUM_W      = 64;
   localparam int STEPS      = 4;
   localparam int DIV_STAGES = (IDX_W + STEPS - 1) / STEPS;

   localparam logic [CSR_IDX_W-1:0] CSR_DIM         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXT_BASE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_BASE = 3'd4;

   localparam logic [IDX_W-1:0] OFFSET_MAX = {IDX_W{1'b1}};

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_DIM,
      ERR_EXTENT,
      ERR_OVERFLOW
   } err_type;

endpackage

>>> src/fiso_div_stage.sv
module fiso_div_stage
   import fiso_pkg::*;
#(
   parameter int NSLOT     = 3,
   parameter int SLOT      = 0,
   parameter int FIRST_BIT = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          prev_valid,
   input  logic [IDX_W-1:0]              prev_dq,
   input  logic [EXT_W-1:0]              prev_rem,
   input  logic [NSLOT-1:0][EXT_W-1:0]   prev_coord,
   input  logic [EXT_W-1:0]              divisor,
   output logic                          valid_ff,
   output logic [IDX_W-1:0]              dq_ff,
   output logic [EXT_W-1:0]              rem_ff,
   output logic [NSLOT-1:0][EXT_W-1:0]   coord_ff
);

   logic [EXT_W-1:0]            seed_rem;
   logic [NSLOT-1:0][EXT_W-1:0] coord_in;
   logic [IDX_W-1:0]            dq_in;
   logic [EXT_W-1:0]            rem_in;
   logic [EXT_W:0]              trial;

   generate
      if (FIRST_BIT == 0 && SLOT > 0) begin : g_entry
         always_comb begin
            seed_rem = '0;
            coord_in = prev_coord;
            coord_in[SLOT-1] = prev_rem;
         end
      end else if (FIRST_BIT == 0) begin : g_first
         always_comb begin
            seed_rem = '0;
            coord_in = prev_coord;
         end
      end else begin : g_mid
         always_comb begin
            seed_rem = prev_rem;
            coord_in = prev_coord;
         end
      end
   endgenerate

   always_comb begin
      dq_in  = prev_dq;
      rem_in = seed_rem;
      trial  = '0;
      for (int j = 0; j < STEPS; j++) begin
         if (FIRST_BIT + j < IDX_W) begin
            trial = {rem_in, dq_in[IDX_W-1]};
            dq_in = {dq_in[IDX_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
               trial    = trial - {1'b0, divisor};
               dq_in[0] = 1'b1;
            end
            rem_in = trial[EXT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dq_ff    <= dq_in;
         rem_ff   <= rem_in;
         coord_ff <= coord_in;
      end
   end

endmodule

>>> src/fiso_mac.sv
module fiso_mac
   import fiso_pkg::*;
#(
   parameter int NSLOT = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          prev_valid,
   input  logic [IDX_W-1:0]              quot,
   input  logic [NSLOT-1:0][EXT_W-1:0]   coord,
   input  logic [IDX_W-1:0]              stride_outer,
   input  logic [NSLOT-1:0][IDX_W-1:0]   slot_stride,
   input  err_type                       err,
   output logic                          rsp_valid_ff,
   output logic [IDX_W-1:0]              offset_ff,
   output err_type                       code_ff
);

   localparam int CP_W = EXT_W + IDX_W;

   logic                        prod_valid_ff;
   logic [PROD_W-1:0]           prod_outer_ff;
   logic [NSLOT-1:0][CP_W-1:0]  prod_ff;
   logic                        sum_valid_ff;
   logic [SUM_W-1:0]            sum_ff;
   logic [SUM_W-1:0]            sum_in;
   logic [IDX_W-1:0]            offset_in;
   err_type                     code_in;

   always_comb begin
      sum_in = SUM_W'(prod_outer_ff);
      for (int k = 0; k < NSLOT; k++) begin
         sum_in = sum_in + SUM_W'(prod_ff[k]);
      end
   end

   always_comb begin
      if (err != ERR_NONE) begin
         offset_in = '0;
         code_in   = err;
      end else if (|sum_ff[SUM_W-1:IDX_W]) begin
         offset_in = OFFSET_MAX;
         code_in   = ERR_OVERFLOW;
      end else begin
         offset_in = sum_ff[IDX_W-1:0];
         code_in   = ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (adv) begin
         prod_valid_ff <= prev_valid;
         sum_valid_ff  <= prod_valid_ff;
         rsp_valid_ff  <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_outer_ff <= PROD_W'(quot) * PROD_W'(stride_outer);
         for (int k = 0; k < NSLOT; k++) begin
            prod_ff[k] <= CP_W'(coord[k]) * CP_W'(slot_stride[k]);
         end
         sum_ff    <= sum_in;
         offset_ff <= offset_in;
         code_ff   <= code_in;
      end
   end

endmodule

>>> src/flat_index_to_strided_offset.sv
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | req_flat_index
// rsp     | out       | rsp_valid/rsp_stall  | rsp_element_offset, rsp_error_code
// csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
// One beat accepted per cycle while rsp is not stalled. The pipe is a chain of
// pipelined dividers (four quotient bits per stage, one divider per
// inner dimension) followed by product, sum and output stages.
// Reset is synchronous; it clears all valid bits and loads register defaults.
// A stalled rsp beat freezes the whole pipe and raises req_stall.
module flat_index_to_strided_offset
   import fiso_pkg::*;
#(
   parameter int MAX_DIMS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [IDX_W-1:0]      req_flat_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [IDX_W-1:0]      rsp_element_offset,
   output logic [1:0]            rsp_error_code,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int NSLOT = MAX_DIMS - 1;
   localparam int NDS   = NSLOT * DIV_STAGES;

   logic [DIM_W-1:0]            dim_ff;
   logic [EXT_W-1:0]            ext_ff    [1:NSLOT];
   logic [IDX_W-1:0]            stride_ff [0:MAX_DIMS-1];

   logic [NSLOT-1:0][EXT_W-1:0] slot_div;
   logic [NSLOT-1:0][IDX_W-1:0] slot_stride;
   err_type                     err;
   logic                        adv;

   logic                        st_valid [0:NDS];
   logic [IDX_W-1:0]            st_dq    [0:NDS];
   logic [EXT_W-1:0]            st_rem   [0:NDS];
   logic [NSLOT-1:0][EXT_W-1:0] st_coord [0:NDS];
   logic [NSLOT-1:0][EXT_W-1:0] mac_coord;
   logic                        out_valid;
   err_type                     out_code;

   assign adv       = !out_valid || !rsp_stall;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid;
   assign rsp_error_code = out_code;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= DIM_W'(2);
         for (int i = 1; i <= NSLOT; i++) begin
            ext_ff[i] <= EXT_W'(1);
         end
         for (int j = 0; j < MAX_DIMS; j++) begin
            stride_ff[j] <= IDX_W'(1);
         end
      end else if (csr_valid) begin
         if (csr_index == CSR_DIM) begin
            dim_ff <= csr_data[DIM_W-1:0];
         end
         for (int i = 1; i <= NSLOT; i++) begin
            if (csr_index == CSR_EXT_BASE + CSR_IDX_W'(i - 1)) begin
               ext_ff[i] <= csr_data[EXT_W-1:0];
            end
         end
         for (int j = 0; j < MAX_DIMS; j++) begin
            if (csr_index == CSR_STRIDE_BASE + CSR_IDX_W'(j)) begin
               stride_ff[j] <= csr_data[IDX_W-1:0];
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NSLOT; k++) begin
         slot_div[k]    = EXT_W'(1);
         slot_stride[k] = '0;
         for (int p = 1; p <= NSLOT; p++) begin
            if (int'(dim_ff) == p + 1 + k) begin
               slot_div[k]    = ext_ff[p];
               slot_stride[k] = stride_ff[p];
            end
         end
      end
   end

   always_comb begin
      err = ERR_NONE;
      if (int'(dim_ff) < 2 || int'(dim_ff) > MAX_DIMS) begin
         err = ERR_DIM;
      end else begin
         for (int p = 1; p <= NSLOT; p++) begin
            if (p < int'(dim_ff) && ext_ff[p] == '0) begin
               err = ERR_EXTENT;
            end
         end
      end
   end

   assign st_valid[0] = req_valid;
   assign st_dq[0]    = req_flat_index;
   assign st_rem[0]   = '0;
   assign st_coord[0] = '0;

   genvar gk, gs;
   generate
      for (gk = 0; gk < NSLOT; gk++) begin : g_slot
         for (gs = 0; gs < DIV_STAGES; gs++) begin : g_stage
            fiso_div_stage #(
               .NSLOT     (NSLOT),
               .SLOT      (gk),
               .FIRST_BIT (gs * STEPS)
            ) u_div (
               .clock      (clock),
               .reset      (reset),
               .adv        (adv),
               .prev_valid (st_valid[gk*DIV_STAGES + gs]),
               .prev_dq    (st_dq[gk*DIV_STAGES + gs]),
               .prev_rem   (st_rem[gk*DIV_STAGES + gs]),
               .prev_coord (st_coord[gk*DIV_STAGES + gs]),
               .divisor    (slot_div[gk]),
               .valid_ff   (st_valid[gk*DIV_STAGES + gs + 1]),
               .dq_ff      (st_dq[gk*DIV_STAGES + gs + 1]),
               .rem_ff     (st_rem[gk*DIV_STAGES + gs + 1]),
               .coord_ff   (st_coord[gk*DIV_STAGES + gs + 1])
            );
         end
      end
   endgenerate

   always_comb begin
      mac_coord = st_coord[NDS];
      mac_coord[NSLOT-1] = st_rem[NDS];
   end

   fiso_mac #(
      .NSLOT (NSLOT)
   ) u_mac (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .prev_valid   (st_valid[NDS]),
      .quot         (st_dq[NDS]),
      .coord        (mac_coord),
      .stride_outer (stride_ff[0]),
      .slot_stride  (slot_stride),
      .err          (err),
      .rsp_valid_ff (out_valid),
      .offset_ff    (rsp_element_offset),
      .code_ff      (out_code)
   );

endmodule

>>> src/fiso_checker.sv
module fiso_checker
   import fiso_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic [IDX_W-1:0]      req_flat_index,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [IDX_W-1:0]      rsp_element_offset,
   input logic [1:0]            rsp_error_code,
   input logic                  csr_valid,
   input logic                  csr_ready,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_data
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_element_offset)
         && $stable(rsp_error_code))
      else $error("held rsp beat changed");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("req taken while rsp stalled");

   a_saturate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == ERR_OVERFLOW |-> rsp_element_offset == OFFSET_MAX)
      else $error("overflow beat not saturated");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code == ERR_DIM || rsp_error_code == ERR_EXTENT)
         |-> rsp_element_offset == '0)
      else $error("error beat carries nonzero offset");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind flat_index_to_strided_offset fiso_checker u_fiso_checker (.*);
